// ===== rtl/slt_pkg.sv =====
package slt_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECOUNT_W = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_DELETE = 2'd2
  } slt_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_POS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } slt_status_e;

  // shared controls broadcast to every cell of the row
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ===== rtl/slt_cell.sv =====
module slt_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk_i,
  input  slt_pkg::cell_ctl_t            ctl_i,
  input  logic                          valid_i,
  input  logic signed [VALUE_WIDTH-1:0] new_value_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic                          left_place_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          place_o,
  output logic signed [VALUE_WIDTH-1:0] read_o
);
  import slt_pkg::*;

  // one-based position of this cell
  localparam logic [POS_W:0] MY_POS = (POS_W+1)'(INDEX + 1);

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic                          hit;
  logic                          at_or_after;

  // an empty cell or one holding a value not below the new one lies at or past the slot
  assign place_o     = !valid_i || (value_q >= new_value_i);
  assign hit         = ({1'b0, ctl_i.pos} == MY_POS);
  assign at_or_after = ({1'b0, ctl_i.pos} <= MY_POS);
  assign value_o     = value_q;
  assign read_o      = hit ? value_q : '0;

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins_en) begin
      if (left_place_i) begin
        value_d = left_value_i;
      end else if (place_o) begin
        value_d = new_value_i;
      end
    end else if (ctl_i.del_en && at_or_after) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== rtl/sorted_list_table.sv =====
// sorted table of signed values, kept in ascending order in a row of cells
// command channel: a request is taken on a clock edge where start is high and
// busy is low; action_i selects insert (item_value_i), read or delete at the
// one-based position_i
// busy stays low: every cell compares and shifts in the same cycle, so a new
// request may be given on every clock, one item per cycle
// the result is registered and appears in the cycle after the request, on found_value_o, status_o and
// entry_count_o, marked by done_o for exactly one cycle; it is not held, and the
// receiver has no way to stall it
// status: ok, position not present, table empty (checked first), table full
// the insert slot comes from the first stored value not below the new value,
// found by each cell against its own contents; the later cells shift up
// delete shifts the cells after the position down by one
// reset empties the table at once (fill count to zero); the cell contents are
// not cleared, since only entries below the fill count are ever read
module sorted_list_table #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [slt_pkg::ACTION_W-1:0]          action_i,
  input  logic signed [slt_pkg::ITEM_W-1:0]     item_value_i,
  input  logic [slt_pkg::POS_W-1:0]             position_i,
  output logic                                  done_o,
  output logic signed [slt_pkg::ITEM_W-1:0]     found_value_o,
  output logic [slt_pkg::STATUS_W-1:0]          status_o,
  output logic [slt_pkg::ECOUNT_W-1:0]          entry_count_o
);
  import slt_pkg::*;

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]                 count_q, count_d;
  logic                          done_q;
  logic signed [ITEM_W-1:0]      found_q, found_d;
  slt_status_e                   status_q, status_d;

  logic                          req;
  logic                          empty, full, pos_ok;
  logic signed [VALUE_WIDTH-1:0] new_value;
  logic signed [VALUE_WIDTH-1:0] read_value;
  cell_ctl_t                     ctl;

  logic        [DEPTH-1:0]                  valid;
  logic        [DEPTH-1:0]                  place;
  logic signed [DEPTH-1:0][VALUE_WIDTH-1:0] value;
  logic signed [DEPTH-1:0][VALUE_WIDTH-1:0] rd;

  assign busy      = 1'b0;
  assign req       = start && !busy;
  assign new_value = VALUE_WIDTH'(item_value_i);
  assign empty     = (count_q == '0);
  assign full      = (count_q == CW'(DEPTH));
  assign pos_ok    = (position_i != '0) && (CMP_W'(position_i) <= CMP_W'(count_q));

  // read port: every cell drives zero unless it sits at the requested position
  always_comb begin
    read_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_value = read_value | rd[i];
    end
  end

  always_comb begin
    ctl.ins_en = 1'b0;
    ctl.del_en = 1'b0;
    ctl.pos    = position_i;
    count_d    = count_q;
    found_d    = '0;
    status_d   = ST_OK;
    if (req) begin
      unique case (slt_action_e'(action_i))
        ACT_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl.ins_en = 1'b1;
            count_d    = count_q + CW'(1);
          end
        end
        ACT_READ, ACT_DELETE: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else if (!pos_ok) begin
            status_d = ST_NO_POS;
          end else begin
            found_d = ITEM_W'(read_value);
            if (slt_action_e'(action_i) == ACT_DELETE) begin
              ctl.del_en = 1'b1;
              count_d    = count_q - CW'(1);
            end
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_place;
    logic signed [VALUE_WIDTH-1:0] right_value;

    assign valid[g] = (count_q > CW'(g));

    if (g == 0) begin : g_first
      assign left_value = new_value;
      assign left_place = 1'b0;
    end else begin : g_mid
      assign left_value = value[g-1];
      assign left_place = place[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_value = value[g];
    end else begin : g_inner
      assign right_value = value[g+1];
    end

    slt_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (valid[g]),
      .new_value_i (new_value),
      .left_value_i(left_value),
      .left_place_i(left_place),
      .right_value_i(right_value),
      .value_o     (value[g]),
      .place_o     (place[g]),
      .read_o      (rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= req;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
  end

  assign done_o        = done_q;
  assign found_value_o = found_q;
  assign status_o      = status_q;
  assign entry_count_o = ECOUNT_W'(count_q);

endmodule

// ===== tb/sorted_list_table_checker.sv =====
module sorted_list_table_checker #(
  parameter int DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic [slt_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [slt_pkg::ITEM_W-1:0]   item_value_i,
  input  logic [slt_pkg::POS_W-1:0]           position_i,
  input  logic                                done_o,
  input  logic signed [slt_pkg::ITEM_W-1:0]   found_value_o,
  input  logic [slt_pkg::STATUS_W-1:0]        status_o,
  input  logic [slt_pkg::ECOUNT_W-1:0]        entry_count_o,
  output int                                  mismatch_count_o,
  output int                                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  typedef struct packed {
    logic signed [ITEM_W-1:0] value;
    slt_status_e              status;
    logic [ECOUNT_W-1:0]      count;
  } table_reply_t;

  logic signed [ITEM_W-1:0] shadow_rows [DEPTH];
  int                       shadow_fill;
  table_reply_t             pending_replies [$];
  table_reply_t             oldest_reply;

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
    shadow_fill      = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%t sorted_list_table mismatch: %s", $realtime, what);
    mismatch_count_o++;
  endtask

  // applies one request to the shadow table and returns the reply it should give
  function automatic table_reply_t apply_request(input logic [ACTION_W-1:0]      act,
                                                 input logic signed [ITEM_W-1:0] val,
                                                 input logic [POS_W-1:0]         pos);
    table_reply_t reply;
    int           slot;
    reply.value  = '0;
    reply.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          // new value goes ahead of any equal ones
          slot = shadow_fill;
          for (int i = shadow_fill - 1; i >= 0; i--) begin
            if (shadow_rows[i] >= val) slot = i;
          end
          for (int i = shadow_fill; i > slot; i--) shadow_rows[i] = shadow_rows[i-1];
          shadow_rows[slot] = val;
          shadow_fill++;
        end
      end
      ACT_READ, ACT_DELETE: begin
        if (shadow_fill == 0) begin
          reply.status = ST_EMPTY;
        end else if (pos == 0 || int'(pos) > shadow_fill) begin
          reply.status = ST_NO_POS;
        end else begin
          reply.value = shadow_rows[pos-1];
          if (act == ACT_DELETE) begin
            for (int i = int'(pos) - 1; i + 1 < shadow_fill; i++) shadow_rows[i] = shadow_rows[i+1];
            shadow_fill--;
          end
        end
      end
      default: begin
      end
    endcase
    reply.count = shadow_fill[ECOUNT_W-1:0];
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      pending_replies.delete();
    end else begin
      // the reply for a request taken at the previous edge is checked before
      // this edge's request is queued
      if (done_o === 1'b1) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected reply: value %0d status %0d count %0d",
                                    found_value_o, status_o, entry_count_o));
        end else begin
          oldest_reply = pending_replies.pop_front();
          if (found_value_o !== oldest_reply.value)
            report_mismatch($sformatf("found_value %0d, expected %0d",
                                      found_value_o, oldest_reply.value));
          if (status_o !== oldest_reply.status)
            report_mismatch($sformatf("status %0d, expected %s",
                                      status_o, oldest_reply.status.name()));
          if (entry_count_o !== oldest_reply.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      entry_count_o, oldest_reply.count));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_replies.push_back(apply_request(action_i, item_value_i, position_i));
    end
    outstanding_o = pending_replies.size();
  end

endmodule

// ===== tb/sorted_list_table_tb.sv =====
module sorted_list_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int                  DEPTH         = 16;
  localparam logic [ACTION_W-1:0] ACT_UNUSED    = 2'd3;
  localparam int                  PHASE_ITEMS   = 370;
  localparam int                  DRAIN_LIMIT   = 2000;
  localparam int                  SETTLE_CYCLES = 4;

  typedef enum int {FILL_UP, DRAIN, MIXED} load_mode_e;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     start        = 1'b0;
  logic                     busy;
  logic [ACTION_W-1:0]      action_i     = '0;
  logic signed [ITEM_W-1:0] item_value_i = '0;
  logic [POS_W-1:0]         position_i   = '0;
  logic                     done_o;
  logic signed [ITEM_W-1:0] found_value_o;
  logic [STATUS_W-1:0]      status_o;
  logic [ECOUNT_W-1:0]      entry_count_o;
  int                       mismatch_count;
  int                       outstanding;
  int                       sender_idle_pct = 33;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sorted_list_table #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(ITEM_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .item_value_i (item_value_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .found_value_o(found_value_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  sorted_list_table_checker #(
    .DEPTH(DEPTH)
  ) reply_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .item_value_i    (item_value_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .found_value_o   (found_value_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  // start stays high across back-to-back requests; it drops only for an idle gap
  task automatic issue(input logic [ACTION_W-1:0]      act,
                       input logic signed [ITEM_W-1:0] val,
                       input logic [POS_W-1:0]         pos);
    start        <= 1'b1;
    action_i     <= act;
    item_value_i <= val;
    position_i   <= pos;
    do @(posedge clk_i); while (busy !== 1'b0);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic random_request(input load_mode_e mode);
    int unsigned              pick;
    int unsigned              ins_cut;
    int unsigned              read_cut;
    logic [ACTION_W-1:0]      act;
    logic signed [ITEM_W-1:0] val;
    logic [POS_W-1:0]         pos;
    case (mode)
      FILL_UP: begin ins_cut = 75; read_cut = 87; end
      DRAIN:   begin ins_cut = 15; read_cut = 30; end
      default: begin ins_cut = 40; read_cut = 70; end
    endcase
    pick = $urandom_range(99);
    if (pick < ins_cut) act = ACT_INSERT;
    else if (pick < read_cut) act = ACT_READ;
    else if (pick < 98) act = ACT_DELETE;
    else act = ACT_UNUSED;

    pick = $urandom_range(9);
    if (pick < 4) val = $urandom;
    else if (pick < 8) val = $signed(int'($urandom_range(8)) - 4); // plenty of duplicates
    else if (pick == 8) val = 32'sh7fff_ffff;
    else val = 32'sh8000_0000;

    pick = $urandom_range(99);
    if (pick < 45) pos = POS_W'($urandom_range(DEPTH, 1));
    else if (pick < 80) pos = POS_W'($urandom_range(4, 1));
    else if (pick < 90) pos = ($urandom_range(1) != 0) ? 8'd0 : 8'(DEPTH + 1);
    else pos = POS_W'($urandom_range(255));
    issue(act, val, pos);
  endtask

  task automatic random_phase(input int idle_pct);
    load_mode_e mode;
    int         run_left;
    sender_idle_pct = idle_pct;
    run_left = 0;
    mode = MIXED;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (run_left == 0) begin
        mode = load_mode_e'($urandom_range(2));
        run_left = $urandom_range(60, 20);
      end
      run_left--;
      random_request(mode);
    end
  endtask

  initial begin
    int waited;
    bit lost_replies;
    lost_replies = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then a single entry deleted again
    issue(ACT_READ, 32'sd0, 8'd1);
    issue(ACT_DELETE, 32'sd0, 8'd1);
    issue(ACT_UNUSED, 32'sd9, 8'd1);
    issue(ACT_INSERT, 32'sd5, 8'd0);
    issue(ACT_DELETE, 32'sd0, 8'd1);
    // extremes and equal values
    issue(ACT_INSERT, 32'sh7fff_ffff, 8'd0);
    issue(ACT_INSERT, 32'sh8000_0000, 8'd0);
    issue(ACT_INSERT, 32'sd0, 8'd0);
    issue(ACT_INSERT, 32'sd0, 8'd0);
    issue(ACT_INSERT, -32'sd1, 8'd0);
    // out-of-range positions, then the first and last entries
    issue(ACT_READ, 32'sd0, 8'd0);
    issue(ACT_READ, 32'sd0, 8'd6);
    issue(ACT_READ, 32'sd0, 8'd255);
    issue(ACT_READ, 32'sd0, 8'd1);
    issue(ACT_READ, 32'sd0, 8'd5);
    // delete at the end, the front and the middle
    issue(ACT_DELETE, 32'sd0, 8'd5);
    issue(ACT_DELETE, 32'sd0, 8'd1);
    issue(ACT_DELETE, 32'sd0, 8'd2);
    issue(ACT_UNUSED, -32'sd1, 8'd255);
    issue(ACT_DELETE, 32'sd0, 8'd0);
    issue(ACT_DELETE, 32'sd0, 8'd2);
    issue(ACT_DELETE, 32'sd0, 8'd1);

    random_phase(33);
    random_phase(72);
    random_phase(0);
    start <= 1'b0;

    waited = 0;
    do begin
      @(negedge clk_i);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    if (outstanding != 0) begin
      $display("%t %0d replies never arrived", $realtime, outstanding);
      lost_replies = 1'b1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && !lost_replies) begin
      $display("sorted_list_table_tb: done, clean");
    end else begin
      $display("sorted_list_table_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("%t timed out", $realtime);
    $display("sorted_list_table_tb: done, errors");
    $finish;
  end

endmodule
